// ===== sv/lwma_pkg.sv =====
// Shared constants and types for the linearly weighted moving average block.
`default_nettype none
package lwma_pkg;
    localparam int WINDOW = 61;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PSUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_W = $clog2(WINDOW * (WINDOW + 1) / 2 + 1);
    localparam int WSUM_W = DIV_W + SAMPLE_W;
    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;
endpackage
`default_nettype wire

// ===== sv/lwma_cell.sv =====
// One stage of the sample shift line, holding a single stored sample.
`default_nettype none
module lwma_cell import lwma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire logic [SAMPLE_W-1:0] i_data,
    output logic      [SAMPLE_W-1:0] o_data
);
    logic [SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

// ===== sv/lwma_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lwma_div import lwma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [WSUM_W-1:0]   i_dividend,
    input  wire logic [DIV_W-1:0]    i_divisor,
    output t_div_status              o_status,
    output logic      [SAMPLE_W-1:0] o_quotient
);
    logic [WSUM_W-1:0]   r_rem;
    logic [WSUM_W-1:0]   r_den;
    logic [SAMPLE_W-1:0] r_quot;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;
    logic                w_fit;

    assign w_fit = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SAMPLE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_den  <= WSUM_W'(i_divisor) << (SAMPLE_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[SAMPLE_W-2:0], w_fit};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quot;
endmodule
`default_nettype wire

// ===== sv/linear_weighted_moving_average.sv =====
// Top level: linearly weighted moving average over a shift line of sample cells.
// An accepted input beat updates the sums, starts the divider, waits for it and then loads the result register.
// A new beat is taken only after the 16-step divider has finished and its result is loaded for the output.
// An input beat is taken while an earlier result still waits on the output register.
// Reset is synchronous and active low; it clears the count and sums, not the samples.
`default_nettype none
module linear_weighted_moving_average import lwma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SAMPLE_W-1:0] i_sample_current,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic      [SAMPLE_W-1:0] o_weighted_average
);
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic [PSUM_W-1:0]   r_psum;
    logic [PSUM_W-1:0]   n_psum;
    logic [WSUM_W-1:0]   r_wsum;
    logic [WSUM_W-1:0]   n_wsum;
    logic [DIV_W-1:0]    r_divisor;
    logic [DIV_W-1:0]    n_divisor;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    logic                w_accept;
    logic                w_filling;
    logic [CNT_W-1:0]    w_weight;
    logic [WSUM_W-1:0]   w_prod;
    logic                w_start;
    logic                w_load;
    logic                w_out_free;
    t_div_status         w_div_status;
    logic [SAMPLE_W-1:0] w_quotient;
    logic [SAMPLE_W-1:0] w_line [WINDOW];

    assign w_accept   = i_valid && !o_stall;
    assign w_filling  = (r_fill < WIN_CNT);
    assign w_out_free = !r_out_valid || !i_stall;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == 0) begin : g_head
                lwma_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_accept),
                    .i_data (i_sample_current),
                    .o_data (w_line[g])
                );
            end else begin : g_body
                lwma_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(w_accept),
                    .i_data (w_line[g-1]),
                    .o_data (w_line[g])
                );
            end
        end
    endgenerate

    assign w_weight = w_filling ? (r_fill + 1'b1) : WIN_CNT;
    assign w_prod   = WSUM_W'(w_weight) * WSUM_W'(i_sample_current);

    always_comb begin
        n_fill    = r_fill;
        n_psum    = r_psum;
        n_wsum    = r_wsum;
        n_divisor = r_divisor;
        if (w_accept) begin
            if (w_filling) begin
                n_fill    = r_fill + 1'b1;
                n_psum    = r_psum + PSUM_W'(i_sample_current);
                n_wsum    = r_wsum + w_prod;
                n_divisor = r_divisor + DIV_W'(w_weight);
            end else begin
                n_psum = r_psum - PSUM_W'(w_line[WINDOW-1]) + PSUM_W'(i_sample_current);
                n_wsum = r_wsum - WSUM_W'(r_psum) + w_prod;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (w_div_status.done) n_state = S_HOLD;
            S_HOLD:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        w_start = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_START: w_start = 1'b1;
            S_WAIT:  w_load  = 1'b0;
            S_HOLD:  w_load  = w_out_free;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_psum      <= '0;
            r_wsum      <= '0;
            r_divisor   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_psum    <= n_psum;
            r_wsum    <= n_wsum;
            r_divisor <= n_divisor;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_quotient;
        end
    end

    lwma_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_dividend(r_wsum),
        .i_divisor (r_divisor),
        .o_status  (w_div_status),
        .o_quotient(w_quotient)
    );

    assign o_valid            = r_out_valid;
    assign o_weighted_average = r_out_data;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_CNT)
        else $error("Fill count above the window length.");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_START) && (r_divisor != '0))
        else $error("Accepted beat did not start a division with a nonzero divisor.");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.done |-> (r_state == S_WAIT))
        else $error("Divider finished outside the wait state.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || !i_stall))
        else $error("Result loaded over a stalled output beat.");
endmodule
`default_nettype wire

// ===== tb/sv/lwma_checker.sv =====
// Checker that predicts the weighted average of each accepted sample and compares each result.
`timescale 1ns / 100ps
module lwma_checker import lwma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [SAMPLE_W-1:0] i_average,
    output int                       o_errors,
    output int                       o_pending
);
    localparam int REPORT_LIMIT = 50;

    logic [SAMPLE_W-1:0] history [WINDOW];
    logic [CNT_W-1:0]    stored;
    logic [CNT_W-1:0]    oldest;
    logic [PSUM_W-1:0]   total;
    logic [WSUM_W-1:0]   weighted;
    logic [SAMPLE_W-1:0] averages_due [$];
    logic [SAMPLE_W-1:0] due;
    int                  mismatches = 0;

    function automatic logic [SAMPLE_W-1:0] take_sample(input logic [SAMPLE_W-1:0] x);
        logic [WSUM_W-1:0] n;
        logic [WSUM_W-1:0] triangle;
        if (stored < WIN_CNT) begin
            history[stored] = x;
            stored = stored + 1'b1;
            n = WSUM_W'(stored);
            total = total + PSUM_W'(x);
            weighted = weighted + n * WSUM_W'(x);
        end else begin
            // Every stored weight drops by one and the new sample enters at full weight.
            n = WSUM_W'(WINDOW);
            weighted = weighted - WSUM_W'(total) + n * WSUM_W'(x);
            total = total - PSUM_W'(history[oldest]) + PSUM_W'(x);
            history[oldest] = x;
            oldest = (oldest == WIN_CNT - 1'b1) ? '0 : oldest + 1'b1;
        end
        triangle = n * (n + 1'b1) / 2;
        return SAMPLE_W'(weighted / triangle);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored = '0;
            oldest = '0;
            total = '0;
            weighted = '0;
            averages_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (averages_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with none due, expected none, actual %0d",
                                 $time, i_average);
                end else begin
                    due = averages_due.pop_front();
                    if (i_average !== due) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: weighted average wrong, expected %0d, actual %0d",
                                     $time, due, i_average);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                averages_due = {averages_due, take_sample(i_sample)};
        end
        o_pending <= averages_due.size();
        o_errors <= mismatches;
    end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: clock, reset, sample stimulus, result stalls and the verdict.
`timescale 1ns / 100ps
module tb import lwma_pkg::*; ();

    localparam int RANDOM_ITEMS  = 700;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_START    = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_START    = 6000;
    localparam int CALM_CYCLES   = 3000;
    localparam int PAUSE_ITEM    = 250;
    localparam int BURST_FIRST   = 400;
    localparam int BURST_LAST    = 520;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    typedef enum int {
        MIX_ANY,
        MIX_MAX,
        MIX_ZERO,
        MIX_LOW,
        MIX_RAILS,
        MIX_NEAR
    } t_mix;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample_current;
    logic                o_valid;
    logic                i_stall;
    logic [SAMPLE_W-1:0] o_weighted_average;
    int                  errors;
    int                  pending;
    int                  cycles = 0;
    int                  send_idle_pct = IDLE_PCT;

    linear_weighted_moving_average dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample_current   (i_sample_current),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_weighted_average (o_weighted_average)
    );

    lwma_checker average_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_sample    (i_sample_current),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_average   (o_weighted_average),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch and later stays ready for a long stretch.
    initial begin
        int clock_count;
        clock_count = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            clock_count++;
            if (clock_count >= HOLD_START && clock_count < HOLD_START + HOLD_CYCLES)
                i_stall <= 1'b1;
            else if (clock_count >= CALM_START && clock_count < CALM_START + CALM_CYCLES)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [SAMPLE_W-1:0] draw_sample(input t_mix mix,
                                                       input logic [SAMPLE_W-1:0] centre);
        case (mix)
            MIX_MAX:   return FULL_SCALE;
            MIX_ZERO:  return '0;
            MIX_LOW:   return SAMPLE_W'($urandom_range(255));
            MIX_RAILS: return ($urandom_range(1) != 0) ? FULL_SCALE : '0;
            MIX_NEAR:  return centre ^ SAMPLE_W'($urandom_range(15));
            default:   return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_current <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    initial begin
        logic [SAMPLE_W-1:0] directed [$];
        logic [SAMPLE_W-1:0] centre;
        t_mix                mix;
        int                  run_left;
        int                  waited;
        directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001,
                     16'hFFFE, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h00FF,
                     16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h0002,
                     16'h1234, 16'hFFFF};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample_current = '0;
        centre = '0;
        mix = MIX_ANY;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            offer_sample(directed[k]);

        run_left = 0;
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (run_left == 0) begin
                mix = ($urandom_range(1) != 0) ? MIX_ANY : t_mix'($urandom_range(MIX_NEAR));
                run_left = $urandom_range(80, 1);
                centre = SAMPLE_W'($urandom);
            end
            run_left--;
            send_idle_pct = (item >= BURST_FIRST && item < BURST_LAST) ? 0 : IDLE_PCT;
            if (item == PAUSE_ITEM) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            offer_sample(draw_sample(mix, centre));
        end

        i_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
